@@ hdl/rgbc_pkg.sv @@
`timescale 1ns / 1ps
package rgbc_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int X_W       = $clog2(MAX_WIDTH);
  localparam int WCFG_W    = 11;
  localparam int Y_W       = 16;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int COEF_BITS = 16;
  localparam int FRAC_BITS = 12;
  localparam int KROW_W    = 48;
  localparam int PROD_W    = COEF_BITS + CH_W + 1;
  localparam int SUM_W     = PROD_W + 4;
  localparam int CFG_IDX_W = 3;
  localparam int LINE_W    = 2 * PIX_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MID   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOT   = 3'd4;

  localparam logic [WCFG_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [Y_W-1:0]    HEIGHT_RESET = 16'd480;
  localparam logic [KROW_W-1:0] KTOP_RESET   = 48'h0100_0200_0100;
  localparam logic [KROW_W-1:0] KMID_RESET   = 48'h0200_0400_0200;
  localparam logic [KROW_W-1:0] KBOT_RESET   = 48'h0100_0200_0100;

  localparam logic [WCFG_W-1:0] MAX_WIDTH_CFG = WCFG_W'(MAX_WIDTH);
  localparam logic [SUM_W-1:0]  ROUND_HALF    = SUM_W'(1) << (FRAC_BITS - 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [2:0][2:0][PIX_W-1:0] nbhd_t;
  typedef logic [2:0][KROW_W-1:0] kern_t;

  typedef struct packed {
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
    pix_t           pix;
    logic           interior;
    logic           border;
  } meta_t;

  function automatic logic [CH_W-1:0] round_clamp(input logic signed [SUM_W-1:0] s);
    logic [SUM_W-1:0]           t;
    logic [SUM_W-FRAC_BITS-1:0] q;
    logic [CH_W-1:0]            r;
    t = $unsigned(s) + ROUND_HALF;
    q = t[SUM_W-1:FRAC_BITS];
    if (s <= 0) begin
      r = '0;
    end else if (|q[SUM_W-FRAC_BITS-1:CH_W]) begin
      r = '1;
    end else begin
      r = q[CH_W-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/rgbc_ram.sv @@
`timescale 1ns / 1ps
module rgbc_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/rgbc_window.sv @@
`timescale 1ns / 1ps
module rgbc_window (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  rgbc_pkg::pix_t          in_pix,
  input  logic [10:0]             w_cfg,
  input  logic [15:0]             h_cfg,
  input  logic                    geom_clr,
  input  logic                    ld_next,
  output logic                    s1_valid,
  output rgbc_pkg::nbhd_t         nbr,
  output rgbc_pkg::meta_t         meta
);
  import rgbc_pkg::*;

  logic [X_W-1:0]    col_r, col_nxt;
  logic [Y_W-1:0]    row_r, row_nxt;
  logic [WCFG_W-1:0] w_eff;
  logic [Y_W-1:0]    h_eff;
  logic [X_W-1:0]    x;
  logic [Y_W-1:0]    y;
  logic              short_frame;
  logic              acc;
  meta_t             meta_in;

  logic              v1_r;
  meta_t             meta1_r;
  logic              fwd_r;
  logic [LINE_W-1:0] fwd_data_r;
  logic [LINE_W-1:0] ram_q;
  logic [LINE_W-1:0] line;
  logic              we;
  logic [LINE_W-1:0] wdata;
  pix_t              win_r [2][3];

  always_comb begin
    if (w_cfg == '0) begin
      w_eff = WCFG_W'(1);
    end else if (w_cfg > MAX_WIDTH_CFG) begin
      w_eff = MAX_WIDTH_CFG;
    end else begin
      w_eff = w_cfg;
    end
    h_eff = (h_cfg == '0) ? Y_W'(1) : h_cfg;
    x = ({1'b0, col_r} >= w_eff) ? '0 : col_r;
    y = (row_r >= h_eff) ? '0 : row_r;
    short_frame = (w_eff < WCFG_W'(3)) || (h_eff < Y_W'(3));
    meta_in.x        = x;
    meta_in.y        = y;
    meta_in.pix      = in_pix;
    meta_in.interior = !short_frame && (x >= X_W'(2)) && (y >= Y_W'(2));
    meta_in.border   = short_frame || (x == '0) || ({1'b0, x} == w_eff - WCFG_W'(1)) ||
                       (y == '0) || (y == h_eff - Y_W'(1));
    if (({1'b0, x} + WCFG_W'(1)) >= w_eff) begin
      col_nxt = '0;
      row_nxt = ({1'b0, y} + 17'd1 >= {1'b0, h_eff}) ? '0 : y + Y_W'(1);
    end else begin
      col_nxt = x + X_W'(1);
      row_nxt = y;
    end
  end

  assign in_ready = !v1_r || ld_next;
  assign acc      = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n || geom_clr) begin
      col_r <= '0;
      row_r <= '0;
    end else if (acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // write back the entry of the item leaving this stage
  assign we    = v1_r && ld_next;
  assign line  = fwd_r ? fwd_data_r : ram_q;
  assign wdata = {meta1_r.pix, line[LINE_W-1:PIX_W]};

  rgbc_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (we),
    .waddr (meta1_r.x),
    .wdata (wdata),
    .re    (in_ready),
    .raddr (x),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      fwd_r <= 1'b0;
    end else if (in_ready) begin
      v1_r  <= in_valid;
      fwd_r <= we && (meta1_r.x == x);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      meta1_r    <= meta_in;
      fwd_data_r <= wdata;
    end
  end

  // shift the window one column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < 2; c++) begin
        for (int r = 0; r < 3; r++) begin
          win_r[c][r] <= '0;
        end
      end
    end else if (we) begin
      win_r[0]    <= win_r[1];
      win_r[1][0] <= line[PIX_W-1:0];
      win_r[1][1] <= line[LINE_W-1:PIX_W];
      win_r[1][2] <= meta1_r.pix;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nbr[r][0] = win_r[0][r];
      nbr[r][1] = win_r[1][r];
    end
    nbr[0][2] = line[PIX_W-1:0];
    nbr[1][2] = line[LINE_W-1:PIX_W];
    nbr[2][2] = meta1_r.pix;
  end

  assign s1_valid = v1_r;
  assign meta     = meta1_r;

endmodule

@@ hdl/rgbc_mac.sv @@
`timescale 1ns / 1ps
module rgbc_mac (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                s1_valid,
  input  rgbc_pkg::nbhd_t     nbr,
  input  rgbc_pkg::meta_t     meta1,
  input  rgbc_pkg::kern_t     kern,
  output logic                ld2,
  input  logic                ld_out,
  output logic                s3_valid,
  output rgbc_pkg::meta_t     meta3,
  output rgbc_pkg::pix_t      res3
);
  import rgbc_pkg::*;

  logic                     v2_r, v3_r;
  logic                     ld3;
  logic signed [PROD_W-1:0] prod_nxt [3][9];
  logic signed [PROD_W-1:0] prod_r   [3][9];
  logic signed [SUM_W-1:0]  sum_nxt  [3];
  logic signed [SUM_W-1:0]  sum_r    [3];
  meta_t                    meta2_r, meta3_r;

  assign ld3 = !v3_r || ld_out;
  assign ld2 = !v2_r || ld3;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          prod_nxt[ch][r*3+c] =
            $signed({1'b0, nbr[r][c][ch*CH_W +: CH_W]}) *
            $signed(kern[r][c*COEF_BITS +: COEF_BITS]);
        end
      end
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_nxt[ch] = '0;
      for (int k = 0; k < 9; k++) begin
        sum_nxt[ch] = sum_nxt[ch] + SUM_W'(prod_r[ch][k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (ld2) begin
        v2_r <= s1_valid;
      end
      if (ld3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      prod_r  <= prod_nxt;
      meta2_r <= meta1;
    end
    if (ld3) begin
      sum_r   <= sum_nxt;
      meta3_r <= meta2_r;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      res3[ch*CH_W +: CH_W] = round_clamp(sum_r[ch]);
    end
  end

  assign s3_valid = v3_r;
  assign meta3    = meta3_r;

endmodule

@@ hdl/rgb_conv3x3_filter.sv @@
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// in        in_valid / in_ready    in_red, in_green, in_blue
// out       out_valid / out_ready  out_x, out_y, out_red, out_green, out_blue,
//                                  out_last_of_run
// cfg       cfg_we                 cfg_index, cfg_data
//
// One pixel per cycle unless the output stalls.
// A pixel with interior and border results holds the output, interior first.
// Line buffer: one 1024 x 48 RAM read and written once per pixel.
// Synchronous reset clears control; line RAM content stays undefined.
// Stalls propagate back stage by stage; empty stages keep accepting.
module rgb_conv3x3_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_x,
  output logic [15:0] out_y,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import rgbc_pkg::*;

  logic [WCFG_W-1:0] width_r;
  logic [Y_W-1:0]    height_r;
  kern_t             kern_r;
  logic              geom_clr;

  logic              s1_valid;
  nbhd_t             nbr;
  meta_t             meta1;
  logic              ld2;
  logic              ld4;
  logic              s3_valid;
  meta_t             meta3;
  pix_t              res3;

  logic              int_pend_r, bord_pend_r;
  logic [X_W-1:0]    ox_r;
  logic [Y_W-1:0]    oy_r;
  pix_t              res_r, pix_r, out_pix;

  assign geom_clr = cfg_we && ((cfg_index == CFG_IMAGE_WIDTH) ||
                               (cfg_index == CFG_IMAGE_HEIGHT));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      kern_r   <= {KBOT_RESET, KMID_RESET, KTOP_RESET};
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:  width_r   <= cfg_data[WCFG_W-1:0];
        CFG_IMAGE_HEIGHT: height_r  <= cfg_data[Y_W-1:0];
        CFG_KERNEL_TOP:   kern_r[0] <= cfg_data;
        CFG_KERNEL_MID:   kern_r[1] <= cfg_data;
        CFG_KERNEL_BOT:   kern_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  rgbc_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_pix   ({in_blue, in_green, in_red}),
    .w_cfg    (width_r),
    .h_cfg    (height_r),
    .geom_clr (geom_clr),
    .ld_next  (ld2),
    .s1_valid (s1_valid),
    .nbr      (nbr),
    .meta     (meta1)
  );

  rgbc_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .nbr      (nbr),
    .meta1    (meta1),
    .kern     (kern_r),
    .ld2      (ld2),
    .ld_out   (ld4),
    .s3_valid (s3_valid),
    .meta3    (meta3),
    .res3     (res3)
  );

  assign out_valid = int_pend_r || bord_pend_r;
  assign ld4       = !out_valid || (out_ready && !(int_pend_r && bord_pend_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_pend_r  <= 1'b0;
      bord_pend_r <= 1'b0;
    end else if (ld4) begin
      int_pend_r  <= s3_valid && meta3.interior;
      bord_pend_r <= s3_valid && meta3.border;
    end else if (out_ready) begin
      int_pend_r  <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ld4) begin
      ox_r  <= meta3.x;
      oy_r  <= meta3.y;
      res_r <= res3;
      pix_r <= meta3.pix;
    end
  end

  assign out_x           = int_pend_r ? ox_r - X_W'(1) : ox_r;
  assign out_y           = int_pend_r ? oy_r - Y_W'(1) : oy_r;
  assign out_pix         = int_pend_r ? res_r : pix_r;
  assign out_red         = out_pix[CH_W-1:0];
  assign out_green       = out_pix[2*CH_W-1:CH_W];
  assign out_blue        = out_pix[3*CH_W-1:2*CH_W];
  assign out_last_of_run = !(int_pend_r && bord_pend_r);

endmodule

@@ tb/sv/rgbc_result_checker.sv @@
`timescale 1ns / 1ps
module rgbc_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [9:0]  out_x,
  input  logic [15:0] out_y,
  input  logic [7:0]  out_red,
  input  logic [7:0]  out_green,
  input  logic [7:0]  out_blue,
  input  logic        out_last_of_run,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data,
  output int          fail_count,
  output int          pending,
  output int          results_seen,
  output int          interior_count
);
  import rgbc_pkg::*;

  localparam int SHOWN_MAX = 40;

  typedef struct packed {
    logic [X_W-1:0]  x;
    logic [Y_W-1:0]  y;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            last;
  } px_result_t;

  px_result_t        pending_pixels[$];
  logic [WCFG_W-1:0] img_w;
  logic [Y_W-1:0]    img_h;
  kern_t             krow;
  pix_t              line_mem [2*MAX_WIDTH];
  pix_t              win [2][3];
  int                col_cnt;
  int                row_cnt;

  task automatic report_mismatch(input string what, input logic [Y_W-1:0] got,
                                 input logic [Y_W-1:0] want);
    if (fail_count < SHOWN_MAX) begin
      $display("t=%0t result %0d: %s is %0h, expected %0h", $time, results_seen, what,
               got, want);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    int                          w;
    int                          h;
    int                          x;
    int                          y;
    int                          n;
    pix_t                        cur [3];
    pix_t                        pv;
    pix_t                        pix;
    pix_t                        res;
    longint                      acc;
    logic signed [COEF_BITS-1:0] tap;
    px_result_t                  made [2];
    px_result_t                  want;
    if (!rst_n) begin
      img_w = WIDTH_RESET;
      img_h = HEIGHT_RESET;
      krow[0] = KTOP_RESET;
      krow[1] = KMID_RESET;
      krow[2] = KBOT_RESET;
      for (int i = 0; i < 2*MAX_WIDTH; i++) line_mem[i] = '0;
      for (int c = 0; c < 2; c++)
        for (int r = 0; r < 3; r++) win[c][r] = '0;
      col_cnt = 0;
      row_cnt = 0;
      pending_pixels.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_WIDTH: begin
            img_w = cfg_data[WCFG_W-1:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          CFG_IMAGE_HEIGHT: begin
            img_h = cfg_data[Y_W-1:0];
            col_cnt = 0;
            row_cnt = 0;
          end
          CFG_KERNEL_TOP: krow[0] = cfg_data;
          CFG_KERNEL_MID: krow[1] = cfg_data;
          CFG_KERNEL_BOT: krow[2] = cfg_data;
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        w = (img_w == '0) ? 1 : int'(img_w);
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        h = (img_h == '0) ? 1 : int'(img_h);
        if (col_cnt >= w) col_cnt = 0;
        if (row_cnt >= h) row_cnt = 0;
        x = col_cnt;
        y = row_cnt;
        pix = {in_blue, in_green, in_red};
        cur[0] = line_mem[x];
        cur[1] = line_mem[MAX_WIDTH + x];
        cur[2] = pix;
        n = 0;
        if (w >= 3 && h >= 3 && x >= 2 && y >= 2) begin
          for (int ch = 0; ch < 3; ch++) begin
            acc = 0;
            for (int rr = 0; rr < 3; rr++)
              for (int cc = 0; cc < 3; cc++) begin
                pv = (cc == 2) ? cur[rr] : win[cc][rr];
                tap = krow[rr][cc*COEF_BITS +: COEF_BITS];
                acc += longint'(pv[ch*CH_W +: CH_W]) * longint'(tap);
              end
            if (acc <= 0) begin
              res[ch*CH_W +: CH_W] = '0;
            end else begin
              acc = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
              res[ch*CH_W +: CH_W] = (acc > 255) ? 8'hFF : CH_W'(acc);
            end
          end
          made[n] = {X_W'(x - 1), Y_W'(y - 1), res[7:0], res[15:8], res[23:16], 1'b0};
          n++;
          interior_count++;
        end
        if (w < 3 || h < 3 || x == 0 || x == w - 1 || y == 0 || y == h - 1) begin
          made[n] = {X_W'(x), Y_W'(y), pix[7:0], pix[15:8], pix[23:16], 1'b0};
          n++;
        end
        if (n > 0) made[n-1].last = 1'b1;
        for (int i = 0; i < n; i++) pending_pixels.push_back(made[i]);

        line_mem[x] = cur[1];
        line_mem[MAX_WIDTH + x] = pix;
        win[0] = win[1];
        win[1] = cur;
        if (x + 1 >= w) begin
          col_cnt = 0;
          row_cnt = (y + 1 >= h) ? 0 : y + 1;
        end else begin
          col_cnt = x + 1;
        end
      end

      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_pixels.size() == 0) begin
          report_mismatch("unexpected result at out_x", Y_W'(out_x), '0);
        end else begin
          want = pending_pixels.pop_front();
          if (out_x !== want.x) report_mismatch("out_x", Y_W'(out_x), Y_W'(want.x));
          if (out_y !== want.y) report_mismatch("out_y", out_y, want.y);
          if (out_red !== want.red) report_mismatch("out_red", Y_W'(out_red), Y_W'(want.red));
          if (out_green !== want.green) begin
            report_mismatch("out_green", Y_W'(out_green), Y_W'(want.green));
          end
          if (out_blue !== want.blue) begin
            report_mismatch("out_blue", Y_W'(out_blue), Y_W'(want.blue));
          end
          if (out_last_of_run !== want.last) begin
            report_mismatch("out_last_of_run", Y_W'(out_last_of_run), Y_W'(want.last));
          end
        end
      end
      pending <= pending_pixels.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import rgbc_pkg::*;

  localparam int RANDOM_ITEMS = 240;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_ITEMS   = 100;
  localparam int DRAIN_CYCLES = 16;
  localparam int CYCLE_LIMIT  = 400000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_red    = '0;
  logic [7:0]  in_green  = '0;
  logic [7:0]  in_blue   = '0;
  logic        out_ready = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [2:0]  cfg_index = CFG_IMAGE_WIDTH;
  logic [47:0] cfg_data  = '0;
  logic        in_ready;
  logic        out_valid;
  logic [9:0]  out_x;
  logic [15:0] out_y;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic        out_last_of_run;

  int   fail_count;
  int   pending;
  int   results_seen;
  int   interior_count;
  int   tx_idle_pct = 35;
  int   rx_idle_pct = 88;
  bit   hold_req;
  bit   hold_done;
  int   pixels_sent;
  int   settings_used;
  int   cycle_count;
  pix_t last_pix;

  rgb_conv3x3_filter uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rgbc_result_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_red(in_red), .in_green(in_green), .in_blue(in_blue),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x(out_x), .out_y(out_y),
    .out_red(out_red), .out_green(out_green), .out_blue(out_blue),
    .out_last_of_run(out_last_of_run),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending),
    .results_seen(results_seen), .interior_count(interior_count)
  );

  always #2 clk = ~clk;

  task automatic put_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
    last_pix = {b, g, r};
  endtask

  task automatic stream_pixels(input int n);
    logic [7:0] chan [3];
    for (int i = 0; i < n; i++) begin
      while ($urandom_range(99) < tx_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      for (int k = 0; k < 3; k++) begin
        case ($urandom_range(3))
          0: chan[k] = $urandom_range(1) ? 8'hFF : 8'h00;
          1: chan[k] = last_pix[8*k +: 8] + 8'($urandom_range(8)) - 8'd4;
          default: chan[k] = 8'($urandom);
        endcase
      end
      put_pixel(chan[0], chan[1], chan[2]);
    end
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : receiver
    int hold_cnt;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [WCFG_W-1:0] w_cfg;
    logic [Y_W-1:0]    h_cfg;
    logic [KROW_W-1:0] data_word;
    logic [15:0]       lane;
    int                w_eff;
    int                h_eff;
    int                rows;
    int                n;
    int                kind;
    int                rand_items;
    bit                big_done;
    bit                big_now;
    bit                geo;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = CFG_KERNEL_BOT + 1; i < (1 << CFG_IDX_W); i++) begin
      write_reg(CFG_IDX_W'(i), 48'({$urandom, $urandom}));
    end

    // half-tap center: exercises round half up
    settings_used++;
    write_reg(CFG_IMAGE_WIDTH, 48'd3);
    write_reg(CFG_IMAGE_HEIGHT, 48'd3);
    write_reg(CFG_KERNEL_TOP, 48'h0);
    write_reg(CFG_KERNEL_MID, 48'h0000_0800_0000);
    write_reg(CFG_KERNEL_BOT, 48'h0);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) put_pixel(8'd1, 8'd3, 8'd255);
      else put_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, 8'(i * 31));
    end

    // extreme taps: saturation high and negative sums
    wait_idle();
    settings_used++;
    write_reg(CFG_KERNEL_TOP, 48'h7FFF_7FFF_7FFF);
    write_reg(CFG_KERNEL_MID, 48'h8000_8000_8000);
    write_reg(CFG_KERNEL_BOT, 48'h7FFF_7FFF_7FFF);
    for (int i = 0; i < 9; i++) put_pixel(8'hFF, (i / 3 == 1) ? 8'hFF : 8'h00, 8'(i * 28));

    // zero width acts as one column
    wait_idle();
    settings_used++;
    write_reg(CFG_IMAGE_WIDTH, 48'hFFFF_FFFF_F800);
    write_reg(CFG_IMAGE_HEIGHT, 48'd3);
    for (int i = 0; i < 3; i++) put_pixel(8'(i * 100), 8'(255 - i), 8'(i));

    // zero height acts as one row
    wait_idle();
    settings_used++;
    write_reg(CFG_IMAGE_WIDTH, 48'd4);
    write_reg(CFG_IMAGE_HEIGHT, 48'hFFFF_FFFF_0000);
    for (int i = 0; i < 4; i++) put_pixel(8'(i * 60), 8'(i * 7), 8'(255 - i * 60));
    w_eff = 4;
    h_eff = 1;

    rand_items = 0;
    big_done   = 1'b0;
    while (rand_items < RANDOM_ITEMS) begin
      if (rand_items >= 2 * RANDOM_ITEMS / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end else if (rand_items >= RANDOM_ITEMS / 3) begin
        tx_idle_pct = 88;
        rx_idle_pct = 35;
      end
      wait_idle();
      settings_used++;
      big_now = 1'b0;
      geo = (w_eff > 64) || ($urandom_range(2) != 0);
      if (!big_done && rand_items >= RANDOM_ITEMS / 3) begin
        w_cfg    = WCFG_W'($urandom_range(MAX_WIDTH, (1 << WCFG_W) - 1));
        h_cfg    = Y_W'(2);
        geo      = 1'b1;
        big_now  = 1'b1;
        big_done = 1'b1;
      end else if (geo) begin
        case ($urandom_range(9))
          0: w_cfg = '0;
          1: w_cfg = WCFG_W'($urandom_range(1, 2));
          default: w_cfg = WCFG_W'($urandom_range(3, 10));
        endcase
        case ($urandom_range(9))
          0: h_cfg = '0;
          1: h_cfg = Y_W'($urandom_range(1, 2));
          2: h_cfg = '1;
          default: h_cfg = Y_W'($urandom_range(3, 7));
        endcase
      end
      if (geo) begin
        data_word = 48'({$urandom, $urandom});
        data_word[WCFG_W-1:0] = w_cfg;
        write_reg(CFG_IMAGE_WIDTH, data_word);
        data_word = 48'({$urandom, $urandom});
        data_word[Y_W-1:0] = h_cfg;
        write_reg(CFG_IMAGE_HEIGHT, data_word);
        w_eff = (w_cfg == '0) ? 1 : ((w_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(w_cfg));
        h_eff = (h_cfg == '0) ? 1 : int'(h_cfg);
      end

      for (int r = 0; r < 3; r++) begin
        if ($urandom_range(1)) begin
          kind = $urandom_range(4);
          if (kind == 0) begin
            data_word = 48'({$urandom, $urandom});
          end else if (kind == 1) begin
            data_word = (r == 1) ? KMID_RESET : KTOP_RESET;
          end else begin
            for (int k = 0; k < 3; k++) begin
              if (kind == 2) begin
                lane = 16'(int'($urandom_range(1200)) - 600);
              end else if (kind == 3) begin
                case ($urandom_range(3))
                  0: lane = 16'h7FFF;
                  1: lane = 16'h8000;
                  2: lane = 16'h1000;
                  default: lane = 16'hF000;
                endcase
              end else begin
                lane = 16'($urandom_range(1000));
              end
              data_word[16*k +: 16] = lane;
            end
          end
          write_reg(CFG_IDX_W'(CFG_KERNEL_TOP + r), data_word);
        end
      end

      if (big_now) begin
        n = MAX_WIDTH + 20;
      end else begin
        rows = (h_eff > 64) ? $urandom_range(3, 5) : h_eff * $urandom_range(1, 2);
        n = w_eff * rows + $urandom_range(0, 2 * w_eff);
      end
      // stall the output long enough to back up the whole pipe
      if (tx_idle_pct == 0 && !hold_req) begin
        hold_req = 1'b1;
        if (n < HOLD_ITEMS) n = HOLD_ITEMS;
      end
      stream_pixels(n);
      if (!big_now) rand_items += n;
    end

    wait_idle();
    $display("Sent %0d pixels under %0d register settings, rows from 1 to %0d wide,",
             pixels_sent, settings_used, MAX_WIDTH);
    $display("with stalls on both sides; compared %0d results, %0d of them filtered.",
             results_seen, interior_count);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ rgb_conv3x3_filter.f @@
hdl/rgbc_pkg.sv
hdl/rgbc_ram.sv
hdl/rgbc_window.sv
hdl/rgbc_mac.sv
hdl/rgb_conv3x3_filter.sv
tb/sv/rgbc_result_checker.sv
tb/sv/tb.sv
